@@ rtl/tsd_pkg.sv @@
// Shared types and constants for the touchpad swipe detector.
`default_nettype none

package tsd_pkg;

    localparam int THR_BITS    = 13;
    localparam int THR_SQ_BITS = 2 * (THR_BITS + 1);
    localparam int TMO_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int DIR_BITS    = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // reset values of the threshold (50, stored as 51 squared) and timeout
    localparam logic [THR_SQ_BITS-1:0] THR_SQ_RESET = THR_SQ_BITS'(51 * 51);
    localparam logic [TMO_BITS-1:0]    TMO_RESET    = TMO_BITS'(500);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef struct packed {
        logic                   enable;
        logic [THR_SQ_BITS-1:0] thr_sq;   // (threshold + 1) squared
        logic [TMO_BITS-1:0]    timeout;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/tsd_cfg.sv @@
// Configuration register bank of the swipe detector.
`default_nettype none

module tsd_cfg
    import tsd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    logic                   enable_reg, enable_next;
    logic [THR_SQ_BITS-1:0] thr_sq_reg, thr_sq_next;
    logic [TMO_BITS-1:0]    timeout_reg, timeout_next;
    logic [THR_BITS:0]      lim;

    assign cfg_ready = 1'b1;
    // threshold is kept squared so the datapath needs no third multiplier
    assign lim = {1'b0, cfg_data[THR_BITS-1:0]} + {{THR_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        enable_next  = enable_reg;
        thr_sq_next  = thr_sq_reg;
        timeout_next = timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_next  = cfg_data[0];
                CFG_THRESHOLD: thr_sq_next  = {{(THR_SQ_BITS-THR_BITS-1){1'b0}}, lim}
                                            * {{(THR_SQ_BITS-THR_BITS-1){1'b0}}, lim};
                CFG_TIMEOUT:   timeout_next = cfg_data[TMO_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            thr_sq_reg  <= THR_SQ_RESET;
            timeout_reg <= TMO_RESET;
        end
        else
        begin
            enable_reg  <= enable_next;
            thr_sq_reg  <= thr_sq_next;
            timeout_reg <= timeout_next;
        end
    end

    assign cfg.enable  = enable_reg;
    assign cfg.thr_sq  = thr_sq_reg;
    assign cfg.timeout = timeout_reg;

endmodule

`default_nettype wire

@@ rtl/tsd_engine.sv @@
// Gesture state and combinational swipe evaluation.
`default_nettype none

module tsd_engine
    import tsd_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic                  touch_active,
    input  wire logic [COORD_BITS-1:0] touch_x,
    input  wire logic [COORD_BITS-1:0] touch_y,
    input  wire logic [TIME_BITS-1:0]  now_ms,
    input  cfg_t                       cfg,
    output logic                       res_valid,
    output dir_t                       res_dir
);

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;
    localparam int CMP_BITS  = (DIST_BITS > THR_SQ_BITS) ? DIST_BITS : THR_SQ_BITS;

    logic                  in_progress_reg, in_progress_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;
    logic                  prev_active_reg, prev_active_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;

    logic [COORD_BITS:0]   dx, dy, neg_dx, neg_dy;
    logic [COORD_BITS-1:0] ax, ay;
    logic [SQ_BITS-1:0]    sq_x, sq_y;
    logic [DIST_BITS-1:0]  dist2;
    logic [TIME_BITS-1:0]  elapsed, timeout_ext;
    logic                  press, release_evt, expired, far_enough, in_time;

    // displacement from the start point to the last active sample
    assign dx     = {1'b0, prev_x_reg} - {1'b0, start_x_reg};
    assign dy     = {1'b0, prev_y_reg} - {1'b0, start_y_reg};
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign ax     = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ay     = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign sq_x   = {{COORD_BITS{1'b0}}, ax} * {{COORD_BITS{1'b0}}, ax};
    assign sq_y   = {{COORD_BITS{1'b0}}, ay} * {{COORD_BITS{1'b0}}, ay};
    assign dist2  = {1'b0, sq_x} + {1'b0, sq_y};
    assign far_enough = CMP_BITS'(dist2) >= CMP_BITS'(cfg.thr_sq);

    // elapsed time wraps with the timestamp
    assign elapsed     = now_ms - start_time_reg;
    assign timeout_ext = {{(TIME_BITS-TMO_BITS){1'b0}}, cfg.timeout};
    assign in_time     = elapsed < timeout_ext;

    assign press       = !in_progress_reg && touch_active && !prev_active_reg;
    assign release_evt = in_progress_reg && !touch_active && prev_active_reg;
    assign expired     = in_progress_reg && (elapsed > timeout_ext);

    always_comb
    begin
        in_progress_next = in_progress_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        start_time_next  = start_time_reg;
        prev_active_next = prev_active_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        res_valid        = 1'b0;
        if (fire)
        begin
            if (cfg.enable)
            begin
                if (press)
                begin
                    start_x_next     = touch_x;
                    start_y_next     = touch_y;
                    start_time_next  = now_ms;
                    in_progress_next = 1'b1;
                end
                else if (release_evt)
                begin
                    res_valid        = in_time && far_enough;
                    in_progress_next = 1'b0;
                end
                else if (expired)
                begin
                    in_progress_next = 1'b0;
                end
            end
            prev_active_next = touch_active;
            prev_x_next      = touch_x;
            prev_y_next      = touch_y;
        end
    end

    always_comb
    begin
        if (ax > ay)
            res_dir = (!dx[COORD_BITS] && (dx != '0)) ? DIR_RIGHT : DIR_LEFT;
        else
            res_dir = (!dy[COORD_BITS] && (dy != '0)) ? DIR_DOWN : DIR_UP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_progress_reg <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_time_reg  <= '0;
            prev_active_reg <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
        end
        else
        begin
            in_progress_reg <= in_progress_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            start_time_reg  <= start_time_next;
            prev_active_reg <= prev_active_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
        end
    end

    // a result needs a release of a swipe in progress
    a_res_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fire && in_progress_reg && prev_active_reg && !touch_active)
        else $error("swipe result without release");

    // detection off: gesture state holds
    a_hold_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cfg.enable |=> $stable(in_progress_reg) && $stable(start_time_reg))
        else $error("gesture state moved while disabled");

    // a result ends the swipe
    a_res_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !in_progress_reg)
        else $error("swipe still in progress after result");

endmodule

`default_nettype wire

@@ rtl/touch_swipe_detector_core.sv @@
// Top level of the touchpad swipe detector: sample register, engine, result register.
`default_nettype none

//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   touch_active, touch_x, touch_y, now_ms
//  out       output     out_valid / out_stall swipe_direction
//  cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One sample per cycle sustained while no held result blocks the engine. The
//  sample is registered, then evaluated against the gesture state in one pass
//  and the result (if any) lands in the output register. Reset clears gesture
//  state and loads the default configuration; no clearing pass. A stalled
//  result holds in the output register; the sample register still takes a
//  transfer and only back-pressures when both it and the result are held.

module touch_swipe_detector_core
    import tsd_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     touch_active,
    input  wire logic [COORD_BITS-1:0]    touch_x,
    input  wire logic [COORD_BITS-1:0]    touch_y,
    input  wire logic [TIME_BITS-1:0]     now_ms,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [DIR_BITS-1:0]           swipe_direction,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t cfg;

    // sample register
    logic                  s_vld_reg, s_vld_next;
    logic                  s_active_reg, s_active_next;
    logic [COORD_BITS-1:0] s_x_reg, s_x_next;
    logic [COORD_BITS-1:0] s_y_reg, s_y_next;
    logic [TIME_BITS-1:0]  s_now_reg, s_now_next;

    // result register
    logic                  o_vld_reg, o_vld_next;
    dir_t                  o_dir_reg, o_dir_next;

    logic                  in_xfer;
    logic                  advance;   // sample moves through the engine
    logic                  res_valid;
    dir_t                  res_dir;

    tsd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsd_engine #(.COORD_BITS(COORD_BITS)) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .touch_active (s_active_reg),
        .touch_x      (s_x_reg),
        .touch_y      (s_y_reg),
        .now_ms       (s_now_reg),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res_dir      (res_dir)
    );

    // engine runs unless a held result blocks its output slot
    assign advance  = s_vld_reg && !(o_vld_reg && out_stall);
    assign in_stall = s_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s_vld_next    = s_vld_reg;
        s_active_next = s_active_reg;
        s_x_next      = s_x_reg;
        s_y_next      = s_y_reg;
        s_now_next    = s_now_reg;
        if (in_xfer)
        begin
            s_vld_next    = 1'b1;
            s_active_next = touch_active;
            s_x_next      = touch_x;
            s_y_next      = touch_y;
            s_now_next    = now_ms;
        end
        else if (advance)
        begin
            s_vld_next = 1'b0;
        end

        o_vld_next = o_vld_reg;
        o_dir_next = o_dir_reg;
        if (advance)
        begin
            o_vld_next = res_valid;
            if (res_valid)
                o_dir_next = res_dir;
        end
        else if (o_vld_reg && !out_stall)
        begin
            o_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg    <= 1'b0;
            s_active_reg <= 1'b0;
            s_x_reg      <= '0;
            s_y_reg      <= '0;
            s_now_reg    <= '0;
            o_vld_reg    <= 1'b0;
            o_dir_reg    <= DIR_RIGHT;
        end
        else
        begin
            s_vld_reg    <= s_vld_next;
            s_active_reg <= s_active_next;
            s_x_reg      <= s_x_next;
            s_y_reg      <= s_y_next;
            s_now_reg    <= s_now_next;
            o_vld_reg    <= o_vld_next;
            o_dir_reg    <= o_dir_next;
        end
    end

    assign out_valid       = o_vld_reg;
    assign swipe_direction = o_dir_reg;

endmodule

`default_nettype wire

@@ bench/touch_swipe_detector_core_tb.sv @@
// Self-checking testbench for touch_swipe_detector_core: directed and random swipe sequences.

module touch_swipe_detector_core_tb;
    import tsd_pkg::*;

    localparam int COORD_BITS = 12;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     touch_active;
    logic [COORD_BITS-1:0]    touch_x;
    logic [COORD_BITS-1:0]    touch_y;
    logic [TIME_BITS-1:0]     now_ms;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [DIR_BITS-1:0]      swipe_direction;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    touch_swipe_detector_core #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .touch_active   (touch_active),
        .touch_x        (touch_x),
        .touch_y        (touch_y),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .swipe_direction(swipe_direction),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Mirror of the detector configuration, reset values first.
    logic                  det_enable = 1'b0;
    logic [THR_BITS-1:0]   det_thr    = THR_BITS'(50);
    logic [TMO_BITS-1:0]   det_tmo    = TMO_BITS'(500);

    // Mirror of the gesture state; all of it clears on reset.
    logic                  swiping     = 1'b0;
    logic [COORD_BITS-1:0] origin_x    = '0;
    logic [COORD_BITS-1:0] origin_y    = '0;
    logic [TIME_BITS-1:0]  origin_ms   = '0;
    logic                  last_active = 1'b0;
    logic [COORD_BITS-1:0] last_x      = '0;
    logic [COORD_BITS-1:0] last_y      = '0;

    // Directions still owed by the block, oldest first.
    dir_t pending_dirs[$];

    logic [TIME_BITS-1:0] clock_ms;    // running pad clock for random sequences
    bit                   steady = 1'b0; // no sender gaps and no result stalls
    int                   hold_left = 0;
    int                   mismatches = 0;
    dir_t                 want_dir;

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("swipe check: %s, expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Advance the gesture mirror by one accepted sample; queue a direction if
    // this sample completes a valid swipe.
    task automatic track_gesture(input logic act, input logic [COORD_BITS-1:0] x,
                                 input logic [COORD_BITS-1:0] y,
                                 input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] elapsed;
        int     dx;
        int     dy;
        longint dist2;
        longint lim;
        dir_t   d;
        if (det_enable)
        begin
            elapsed = t - origin_ms;   // wraps modulo 2^32
            if (!swiping && act && !last_active)
            begin
                origin_x  = x;
                origin_y  = y;
                origin_ms = t;
                swiping   = 1'b1;
            end
            else if (swiping && !act && last_active)
            begin
                // release: judge the path from the start to the last touched point
                if (elapsed < TIME_BITS'(det_tmo))
                begin
                    dx    = int'(last_x) - int'(origin_x);
                    dy    = int'(last_y) - int'(origin_y);
                    dist2 = longint'(dx) * dx + longint'(dy) * dy;
                    lim   = longint'(det_thr) + 1;
                    if (dist2 >= lim * lim)
                    begin
                        if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy))
                            d = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
                        else
                            d = (dy > 0) ? DIR_DOWN : DIR_UP;
                        pending_dirs.push_back(d);
                    end
                end
                swiping = 1'b0;
            end
            else if (swiping && elapsed > TIME_BITS'(det_tmo))
            begin
                swiping = 1'b0;   // held too long: cancelled
            end
        end
        last_active = act;
        last_x      = x;
        last_y      = y;
    endtask

    // One sample transfer. The valid line is only lowered when a gap is drawn,
    // so back-to-back samples never lower and raise it in the same step.
    task automatic send_sample(input logic act, input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y,
                               input logic [TIME_BITS-1:0] t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        touch_active <= act;
        touch_x      <= x;
        touch_y      <= y;
        now_ms       <= t;
        do @(posedge clk); while (in_stall);
        track_gesture(act, x, y, t);
    endtask

    // Stop sending and wait until every owed direction has arrived, then let
    // the two-stage pipe empty of samples that produce nothing.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic en, input logic [THR_BITS-1:0] thr,
                               input logic [TMO_BITS-1:0] tmo, input bit poke_spare);
        logic [CFG_IDX_BITS-1:0]  idx [4];
        logic [CFG_DATA_BITS-1:0] val [4];
        int n;
        drain_results();
        idx[0] = CFG_ENABLE;    val[0] = CFG_DATA_BITS'(en);
        idx[1] = CFG_THRESHOLD; val[1] = CFG_DATA_BITS'(thr);
        idx[2] = CFG_TIMEOUT;   val[2] = tmo;
        idx[3] = CFG_SPARE;     val[3] = CFG_DATA_BITS'($urandom);
        n = poke_spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_ENABLE:    det_enable = val[i][0];
                CFG_THRESHOLD: det_thr    = val[i][THR_BITS-1:0];
                CFG_TIMEOUT:   det_tmo    = val[i][TMO_BITS-1:0];
                default:       ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Next pad time; now and then a jump anywhere in the 32-bit range.
    function automatic logic [TIME_BITS-1:0] next_time(input int span);
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, span);
        return clock_ms;
    endfunction

    // Move a coordinate by up to +/- reach, clamped to the pad.
    function automatic logic [COORD_BITS-1:0] wander(input logic [COORD_BITS-1:0] v,
                                                     input int reach);
        int r;
        r = int'(v) + int'($urandom_range(0, 2 * reach)) - reach;
        if (r < 0)
            r = 0;
        if (r > int'(COORD_MAX))
            r = int'(COORD_MAX);
        return r[COORD_BITS-1:0];
    endfunction

    // Detection is off after reset: a clear swipe must give nothing.
    task automatic check_disabled_gestures();
        send_sample(1'b1, 12'd100, 12'd100, 32'd10);
        send_sample(1'b1, 12'd3000, 12'd100, 32'd60);
        send_sample(1'b0, 12'd3000, 12'd100, 32'd90);
    endtask

    // One swipe per direction across the full pad; the upward one straddles
    // the 32-bit time wrap.
    task automatic check_each_direction();
        load_config(1'b1, THR_BITS'(50), TMO_BITS'(500), 1'b0);
        send_sample(1'b1, 12'd0, 12'd2048, 32'h0000_1000);
        send_sample(1'b1, COORD_MAX, 12'd2048, 32'h0000_1064);
        send_sample(1'b0, COORD_MAX, 12'd2048, 32'h0000_10C8);
        send_sample(1'b1, COORD_MAX, 12'd0, 32'h0000_2000);
        send_sample(1'b1, 12'd0, 12'd0, 32'h0000_2050);
        send_sample(1'b0, 12'd0, 12'd0, 32'h0000_20A0);
        send_sample(1'b1, 12'd0, 12'd0, 32'h0000_3000);
        send_sample(1'b1, 12'd0, COORD_MAX, 32'h0000_3010);
        send_sample(1'b0, 12'd0, COORD_MAX, 32'h0000_3020);
        send_sample(1'b1, COORD_MAX, COORD_MAX, 32'hFFFF_FF80);
        send_sample(1'b1, COORD_MAX, 12'd0, 32'hFFFF_FFF0);
        send_sample(1'b0, COORD_MAX, 12'd0, 32'h0000_0040);
    endtask

    // Zero threshold with zero timeout (cancel on the first later sample),
    // then the largest threshold that a corner-to-corner diagonal still beats
    // with the longest timeout; equal |dx| and |dy| resolves to vertical.
    task automatic check_config_extremes();
        load_config(1'b1, THR_BITS'(0), TMO_BITS'(0), 1'b1);
        send_sample(1'b1, 12'd10, 12'd10, 32'h0001_0000);
        send_sample(1'b1, 12'd11, 12'd10, 32'h0001_0001);
        send_sample(1'b0, 12'd11, 12'd10, 32'h0001_0002);
        load_config(1'b1, THR_BITS'(5790), TMO_BITS'(16'hFFFF), 1'b0);
        send_sample(1'b1, 12'd0, 12'd0, 32'h8000_0000);
        send_sample(1'b1, COORD_MAX, COORD_MAX, 32'h8000_7530);
        send_sample(1'b0, COORD_MAX, COORD_MAX, 32'h8000_FFFE);
    endtask

    // A release seen while disabled leaves the swipe open; the next touch is
    // then a press during a swipe and must not restart it.
    task automatic check_paused_gesture();
        load_config(1'b1, THR_BITS'(50), TMO_BITS'(500), 1'b0);
        send_sample(1'b1, 12'd1000, 12'd1000, 32'h0002_0000);
        load_config(1'b0, THR_BITS'(50), TMO_BITS'(500), 1'b0);
        send_sample(1'b0, 12'd1000, 12'd1000, 32'h0002_000A);
        load_config(1'b1, THR_BITS'(50), TMO_BITS'(500), 1'b0);
        send_sample(1'b1, 12'd3000, 12'd1200, 32'h0002_0014);
        send_sample(1'b0, 12'd3000, 12'd1200, 32'h0002_001E);
    endtask

    // Mostly well-formed touches (lead-in, press, a few moves, release) timed
    // against the current timeout, mixed with random samples.
    task automatic run_gestures(input int budget);
        int sent;
        int moves;
        int span;
        int tmo_i;
        int reach;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        sent = 0;
        while (sent < budget)
        begin
            tmo_i = int'(det_tmo);
            reach = int'(det_thr) + 40;
            if ($urandom_range(0, 9) < 8)
            begin
                moves = $urandom_range(1, 4);
                span  = ($urandom_range(0, 9) == 0) ? 3 * tmo_i + 10 : tmo_i / (moves + 1);
                px    = COORD_BITS'($urandom_range(0, COORD_MAX));
                py    = COORD_BITS'($urandom_range(0, COORD_MAX));
                send_sample(1'b0, COORD_BITS'($urandom_range(0, COORD_MAX)),
                            COORD_BITS'($urandom_range(0, COORD_MAX)), next_time(span));
                send_sample(1'b1, px, py, next_time(span));
                repeat (moves)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        px = wander(px, reach);
                        py = wander(py, reach);
                    end
                    else
                    begin
                        px = COORD_BITS'($urandom_range(0, COORD_MAX));
                        py = COORD_BITS'($urandom_range(0, COORD_MAX));
                    end
                    send_sample(1'b1, px, py, next_time(span));
                end
                send_sample(1'b0, COORD_BITS'($urandom_range(0, COORD_MAX)),
                            COORD_BITS'($urandom_range(0, COORD_MAX)), next_time(span));
                sent += moves + 3;
            end
            else
            begin
                send_sample(1'($urandom_range(0, 1)), COORD_BITS'($urandom_range(0, COORD_MAX)),
                            COORD_BITS'($urandom_range(0, COORD_MAX)), next_time(tmo_i));
                sent++;
            end
        end
    endtask

    // Eight configurations, the extremes among them; one phase runs disabled.
    task automatic check_random_gestures();
        logic [THR_BITS-1:0] thr;
        logic [TMO_BITS-1:0] tmo;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1:       thr = THR_BITS'(0);
                2:       thr = THR_BITS'(5791);
                5:       thr = THR_BITS'(5790);
                7:       thr = THR_BITS'($urandom_range(0, 5791));
                default: thr = THR_BITS'($urandom_range(0, 300));
            endcase
            case (p)
                2:       tmo = TMO_BITS'(16'hFFFF);
                6:       tmo = TMO_BITS'(0);
                default: tmo = TMO_BITS'($urandom_range(20, 3000));
            endcase
            load_config(p != 3, thr, tmo, p == 4);
            steady   = ($urandom_range(0, 3) == 0);
            clock_ms = $urandom;
            run_gestures((p == 3) ? 60 : 270);
        end
        steady = 1'b0;
    endtask

    // Result side: check every direction transfer against the oldest owed one,
    // then draw how many cycles to stall before taking the next.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_dirs.size() == 0)
                begin
                    note_mismatch("swipe with none owed", -1, int'(swipe_direction));
                end
                else
                begin
                    want_dir = pending_dirs.pop_front();
                    if (swipe_direction !== want_dir)
                        note_mismatch("swipe_direction", int'(want_dir), int'(swipe_direction));
                end
                hold_left = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int w;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        touch_active = 1'b0;
        touch_x      = '0;
        touch_y      = '0;
        now_ms       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ENABLE;
        cfg_data     = '0;
        clock_ms     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        check_disabled_gestures();
        check_each_direction();
        check_config_extremes();
        check_paused_gesture();
        check_random_gestures();

        // Flush: owed directions must all show up, then allow for the latency.
        in_valid <= 1'b0;
        for (w = 0; w < 5000 && pending_dirs.size() != 0; w++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_dirs.size() != 0)
        begin
            mismatches += pending_dirs.size();
            $display("swipe check: %0d owed directions never arrived", pending_dirs.size());
        end
        if (mismatches == 0)
            $display("touch_swipe_detector_core: match");
        else
            $display("touch_swipe_detector_core: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("touch_swipe_detector_core: mismatch");
        $finish;
    end

endmodule
